// File: hw/rtl/lcp_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the cell parameter unit.
package lcp_pkg;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} vec_t;

	typedef struct packed {
		logic [31:0] len_a;
		logic [31:0] len_b;
		logic [31:0] len_c;
		logic [23:0] angle_alpha;
		logic [23:0] angle_beta;
		logic [23:0] angle_gamma;
		logic        degenerate;
	} par_t;

	localparam logic [23:0] DEG90  = 24'd5898240;
	localparam logic [23:0] DEG180 = 24'd11796480;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam int CORDIC_STEPS = 23;
	localparam int DIV_STEPS = 30;

	// atan(2^-i) in Q6.16 degrees
	function automatic logic [21:0] atan_deg(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/lcp_if.sv
// Valid/ready stream interfaces for lattice vectors and cell parameters.
interface lcp_vec_if;
	logic          valid;
	logic          ready;
	lcp_pkg::vec_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcp_par_if;
	logic          valid;
	logic          ready;
	lcp_pkg::par_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/lcp_delay.sv
// Enabled delay line for side data that travels beside a pipeline.
module lcp_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] pipe_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[D-1];
endmodule

// File: hw/rtl/lcp_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module lcp_isqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);
	localparam int N  = W / 2;
	localparam int RW = N + 3;

	logic [W-1:0]  rad_q  [N+1];
	logic [RW-1:0] rem_q  [N+1];
	logic [N-1:0]  root_q [N+1];

	assign rad_q[0]  = rad;
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		always_comb begin
			rem_sh = {rem_q[k][RW-3:0], rad_q[k][W-1:W-2]};
			trial  = RW'({root_q[k], 2'b01});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k+1] <= rad_q[k] << 2;
				if (rem_sh >= trial) begin
					rem_q[k+1]  <= rem_sh - trial;
					root_q[k+1] <= {root_q[k][N-2:0], 1'b1};
				end else begin
					rem_q[k+1]  <= rem_sh;
					root_q[k+1] <= {root_q[k][N-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[N];
endmodule

// File: hw/rtl/lcp_div.sv
// Pipelined restoring fraction divider, num < den, one quotient bit per stage.
module lcp_div #(
	parameter int W = 64,
	parameter int Q = 30
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [Q-1:0] quo
);
	logic [W-1:0] r_q [Q+1];
	logic [W-1:0] d_q [Q+1];
	logic [Q-1:0] q_q [Q+1];

	assign r_q[0] = num;
	assign d_q[0] = den;
	assign q_q[0] = '0;

	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic [W:0] r2;
		logic       ge;
		always_comb begin
			r2 = {r_q[k], 1'b0};
			ge = r2 >= {1'b0, d_q[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[k+1] <= d_q[k];
				q_q[k+1] <= {q_q[k][Q-2:0], ge};
				r_q[k+1] <= ge ? W'(r2 - {1'b0, d_q[k]}) : W'(r2);
			end
		end
	end

	assign quo = q_q[Q];
endmodule

// File: hw/rtl/lcp_angle.sv
// One angle lane: cosine divide, sine root, CORDIC arccosine and fold to degrees.
module lcp_angle (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] mag,
	input  logic        neg,
	input  logic [31:0] len_u,
	input  logic [31:0] len_w,
	output logic [23:0] angle
);
	localparam int NS = lcp_pkg::CORDIC_STEPS;
	localparam logic [61:0] ONE_SQ = 62'd1 << 60;

	logic [63:0] den_s1, mag_s1, den_s2, mag_s2;
	logic        neg_s1, neg_s2, one_s2;
	logic [29:0] quo;
	logic [1:0]  dly_div;
	logic [30:0] cmag_s3, cmag_s4, cmag_s5;
	logic        neg_s3, neg_s4, neg_s5;
	logic [61:0] sq_s4, rad_s5;
	logic [30:0] sin_m;
	logic [31:0] dly_rt;
	logic [2:0]  dly_cd;
	logic [23:0] zc;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1  <= 64'(len_u) * 64'(len_w);
			mag_s1  <= mag;
			neg_s1  <= neg;
			one_s2  <= mag_s1 >= den_s1;
			mag_s2  <= mag_s1;
			den_s2  <= den_s1;
			neg_s2  <= neg_s1;
		end
	end

	lcp_div #(.W(64), .Q(lcp_pkg::DIV_STEPS)) u_div (
		.clk(clk), .en(en), .num(mag_s2), .den(den_s2), .quo(quo)
	);
	lcp_delay #(.W(2), .D(lcp_pkg::DIV_STEPS)) u_dly_div (
		.clk(clk), .en(en), .d({one_s2, neg_s2}), .q(dly_div)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cmag_s3 <= dly_div[1] ? lcp_pkg::ONE_Q30 : {1'b0, quo};
			neg_s3  <= dly_div[0];
			sq_s4   <= 62'(cmag_s3) * 62'(cmag_s3);
			cmag_s4 <= cmag_s3;
			neg_s4  <= neg_s3;
			rad_s5  <= ONE_SQ - sq_s4;
			cmag_s5 <= cmag_s4;
			neg_s5  <= neg_s4;
		end
	end

	lcp_isqrt #(.W(62)) u_sin (
		.clk(clk), .en(en), .rad(rad_s5), .root(sin_m)
	);
	lcp_delay #(.W(32), .D(31)) u_dly_rt (
		.clk(clk), .en(en), .d({neg_s5, cmag_s5}), .q(dly_rt)
	);

	logic signed [32:0] cx_q [NS+1];
	logic signed [32:0] cy_q [NS+1];
	logic signed [24:0] cz_q [NS+1];

	assign cx_q[0] = {2'b00, dly_rt[30:0]};
	assign cy_q[0] = {2'b00, sin_m};
	assign cz_q[0] = '0;

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic [24:0] at;
		assign at = 25'(lcp_pkg::atan_deg(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_q[i][32] && cy_q[i] != '0) begin
					cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] + $signed(at);
				end else begin
					cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] - $signed(at);
				end
			end
		end
	end

	// flags: negative cosine, zero sine, zero cosine
	lcp_delay #(.W(3), .D(NS)) u_dly_cd (
		.clk(clk), .en(en),
		.d({dly_rt[31], sin_m == '0, dly_rt[30:0] == '0}), .q(dly_cd)
	);

	always_comb begin
		if (dly_cd[1] || cz_q[NS][24]) begin
			zc = '0;
		end else if (dly_cd[0] || cz_q[NS][23:0] > lcp_pkg::DEG90) begin
			zc = lcp_pkg::DEG90;
		end else begin
			zc = cz_q[NS][23:0];
		end
	end

	logic [23:0] angle_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s6 <= dly_cd[2] ? lcp_pkg::DEG180 - zc : zc;
		end
	end

	assign angle = angle_s6;
endmodule

// File: hw/rtl/lattice_vectors_to_cell_params_unit.sv
// Lattice vectors to cell lengths and angles: top level with lanes and merge stage.
// Path from input transfer to result: 2 product/sum stages, 32 stages of the length
// roots, 90 stages of an angle lane, one output register.
// Throughput: one cell per cycle; a stalled output holds the whole pipeline.
// Reset clears the stage valid bits only; no result is pending after reset.
module lattice_vectors_to_cell_params_unit (
	input logic         clk,
	input logic         arst_n,
	lcp_vec_if.sink     vec,
	lcp_par_if.source   par
);
	localparam int LAT = 125;

	logic           en;
	logic [LAT-1:0] vld_q;
	logic signed [31:0] v [3][3];

	assign v[0] = '{vec.data.a_x, vec.data.a_y, vec.data.a_z};
	assign v[1] = '{vec.data.b_x, vec.data.b_y, vec.data.b_z};
	assign v[2] = '{vec.data.c_x, vec.data.c_y, vec.data.c_z};

	assign en        = !vld_q[LAT-1] || par.ready;
	assign vec.ready = en;
	assign par.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], vec.valid};
		end
	end

	logic [31:0] len [3];
	logic [23:0] ang [3];
	logic [96:0] len_d;

	// lane k: norm of vector k and angle between the other two vectors
	for (genvar k = 0; k < 3; k++) begin : g_lane
		localparam int U = (k == 0) ? 1 : 0;
		localparam int W = (k == 2) ? 1 : 2;
		logic        [63:0] nsq_s1 [3];
		logic signed [63:0] dp_s1  [3];
		logic        [63:0] norm_s2;
		logic signed [65:0] dot_s2;
		logic [63:0] mag;
		logic [64:0] dot_d;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					nsq_s1[i] <= v[k][i] * v[k][i];
					dp_s1[i]  <= v[U][i] * v[W][i];
				end
				norm_s2 <= nsq_s1[0] + nsq_s1[1] + nsq_s1[2];
				dot_s2  <= dp_s1[0] + dp_s1[1] + dp_s1[2];
			end
		end

		assign mag = dot_s2[65] ? 64'(-dot_s2) : 64'(dot_s2);

		lcp_isqrt #(.W(64)) u_len (
			.clk(clk), .en(en), .rad(norm_s2), .root(len[k])
		);
		lcp_delay #(.W(65), .D(32)) u_dly_dot (
			.clk(clk), .en(en), .d({dot_s2[65], mag}), .q(dot_d)
		);
		lcp_angle u_angle (
			.clk(clk), .en(en), .mag(dot_d[63:0]), .neg(dot_d[64]),
			.len_u(len[U]), .len_w(len[W]), .angle(ang[k])
		);
	end

	lcp_delay #(.W(97), .D(90)) u_dly_len (
		.clk(clk), .en(en),
		.d({len[0] == '0 || len[1] == '0 || len[2] == '0, len[0], len[1], len[2]}),
		.q(len_d)
	);

	lcp_pkg::par_t par_q;
	always_ff @(posedge clk) begin
		if (en) begin
			par_q.len_a       <= len_d[95:64];
			par_q.len_b       <= len_d[63:32];
			par_q.len_c       <= len_d[31:0];
			par_q.degenerate  <= len_d[96];
			par_q.angle_alpha <= len_d[96] ? '0 : ang[0];
			par_q.angle_beta  <= len_d[96] ? '0 : ang[1];
			par_q.angle_gamma <= len_d[96] ? '0 : ang[2];
		end
	end

	assign par.data = par_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		par.valid && par.data.degenerate |->
		par.data.angle_alpha == '0 && par.data.angle_beta == '0 &&
		par.data.angle_gamma == '0)
		else $error("degenerate cell with nonzero angle");

	a_degen_len: assert property (@(posedge clk) disable iff (!arst_n)
		par.valid |-> par.data.degenerate == (par.data.len_a == '0 ||
		par.data.len_b == '0 || par.data.len_c == '0))
		else $error("degenerate flag disagrees with lengths");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		par.valid |-> par.data.angle_alpha <= lcp_pkg::DEG180 &&
		par.data.angle_beta <= lcp_pkg::DEG180 &&
		par.data.angle_gamma <= lcp_pkg::DEG180)
		else $error("angle above 180 degrees");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
endmodule
